### hw/rtl/m3i_pkg.sv
// ----------------------------------------------------------------------------
// m3i_pkg: shared types and constants of the 3x3 matrix inverse unit
// Payload words, divider pipeline word and common widths.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int NLANE    = 9;     // one lane per inverse entry
    localparam int DETW     = 97;    // determinant, 48 fraction bits, signed
    localparam int COFW     = 65;    // cofactor, 32 fraction bits, signed
    localparam int QW       = 32;    // quotient bits per entry
    localparam int NSTEP    = QW;    // one quotient bit per divider stage

    localparam logic [31:0] LIMIT_RESET = 32'd4295;
    localparam logic [QW-1:0] SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [QW-1:0] SAT_NEG   = 32'h8000_0000;

    localparam logic ADDR_LIMIT = 1'b0;   // register word index of singular_limit

    typedef struct packed {
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
        logic signed [31:0] m31;
        logic signed [31:0] m32;
        logic signed [31:0] m33;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r13;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic signed [31:0] r23;
        logic signed [31:0] r31;
        logic signed [31:0] r32;
        logic signed [31:0] r33;
        logic               singular;
    } t_out_word;

    typedef struct packed {
        logic [DETW-1:0] rem;   // partial remainder, below dmag when ovf is clear
        logic [QW-1:0]   quo;   // quotient bits so far
        logic            neg;   // result sign
        logic            ovf;   // |cof| >= |det|: quotient above 32 bits
    } t_lane;

    typedef struct packed {
        logic                  vld;
        logic                  sing;
        logic [DETW-1:0]       dmag;
        t_lane [NLANE-1:0]     lane;
    } t_div_word;

endpackage

### hw/rtl/m3i_div_step.sv
// ----------------------------------------------------------------------------
// m3i_div_step: one restoring division stage
// Produces one quotient bit for all nine lanes and registers the word.
// ----------------------------------------------------------------------------
module m3i_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  m3i_pkg::t_div_word  i_word,
    output m3i_pkg::t_div_word  o_word
);
    import m3i_pkg::*;

    t_div_word r_word;
    t_div_word n_word;

    always_comb begin
        logic [DETW-1:0] t;
        logic            ge;
        n_word = i_word;
        for (int i = 0; i < NLANE; i++) begin
            t  = {i_word.lane[i].rem[DETW-2:0], 1'b0};
            ge = (t >= i_word.dmag);
            n_word.lane[i].rem = ge ? (t - i_word.dmag) : t;
            n_word.lane[i].quo = {i_word.lane[i].quo[QW-2:0], ge};
        end
    end

    // only the valid bit is cleared by reset; data just holds meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word.vld <= 1'b0;
        end else if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

### hw/rtl/m3i_front.sv
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Seven stages: products, cofactors, partial products, terms, determinant,
// magnitudes, singular and overflow tests. Emits the divider's first word.
// ----------------------------------------------------------------------------
module m3i_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  m3i_pkg::t_in_word   i_word,
    input  logic [31:0]         i_limit,
    output m3i_pkg::t_div_word  o_word
);
    import m3i_pkg::*;

    // stage 1: 18 products, 64 bits
    logic               r1_vld;
    logic signed [63:0] r1_p [18];
    logic signed [63:0] n1_p [18];
    logic signed [31:0] r1_abc [3];
    // stage 2: cofactors
    logic               r2_vld;
    logic signed [COFW-1:0] r2_cof [NLANE];
    logic signed [COFW-1:0] n2_cof [NLANE];
    logic signed [31:0] r2_abc [3];
    // stage 3: split products for the determinant
    logic               r3_vld;
    logic signed [COFW-1:0] r3_pl [3];
    logic signed [COFW-1:0] r3_ph [3];
    logic signed [COFW-1:0] n3_pl [3];
    logic signed [COFW-1:0] n3_ph [3];
    logic signed [COFW-1:0] r3_cof [NLANE];
    // stage 4: determinant terms
    logic               r4_vld;
    logic [DETW-1:0]    r4_term [3];
    logic [DETW-1:0]    n4_term [3];
    logic signed [COFW-1:0] r4_cof [NLANE];
    // stage 5: determinant
    logic               r5_vld;
    logic [DETW-1:0]    r5_det;
    logic signed [COFW-1:0] r5_cof [NLANE];
    // stage 6: magnitudes
    logic               r6_vld;
    logic [DETW-1:0]    r6_dmag;
    logic               r6_dz;
    logic [COFW-1:0]    r6_cmag [NLANE];
    logic               r6_neg [NLANE];
    logic [COFW-1:0]    n6_cmag [NLANE];
    logic               n6_neg [NLANE];
    // stage 7: divider entry word
    t_div_word          r7_word;
    t_div_word          n7_word;

    logic signed [31:0] a, b, c, d, e, f, g, h, k;
    assign a = i_word.m11;
    assign b = i_word.m12;
    assign c = i_word.m13;
    assign d = i_word.m21;
    assign e = i_word.m22;
    assign f = i_word.m23;
    assign g = i_word.m31;
    assign h = i_word.m32;
    assign k = i_word.m33;

    // cofactor i = product 2i minus product 2i+1
    always_comb begin
        n1_p[0]  = e * k;  n1_p[1]  = f * h;
        n1_p[2]  = c * h;  n1_p[3]  = b * k;
        n1_p[4]  = b * f;  n1_p[5]  = c * e;
        n1_p[6]  = f * g;  n1_p[7]  = d * k;
        n1_p[8]  = a * k;  n1_p[9]  = c * g;
        n1_p[10] = c * d;  n1_p[11] = a * f;
        n1_p[12] = d * h;  n1_p[13] = e * g;
        n1_p[14] = b * g;  n1_p[15] = a * h;
        n1_p[16] = a * e;  n1_p[17] = b * d;
    end

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n2_cof[i] = {r1_p[2*i][63], r1_p[2*i]} - {r1_p[2*i+1][63], r1_p[2*i+1]};
        end
    end

    // det = a*cof0 + b*cof3 + c*cof6, each cofactor split at bit 32
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_pl[i] = $signed({1'b0, r2_cof[3*i][31:0]}) * r2_abc[i];
            n3_ph[i] = $signed(r2_cof[3*i][COFW-1:32]) * r2_abc[i];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n4_term[i] = {r3_ph[i], 32'b0} + {{32{r3_pl[i][COFW-1]}}, r3_pl[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < NLANE; i++) begin
            n6_cmag[i] = r5_cof[i][COFW-1] ? (COFW'(0) - r5_cof[i]) : r5_cof[i];
            n6_neg[i]  = r5_cof[i][COFW-1] ^ r5_det[DETW-1];
        end
    end

    always_comb begin
        n7_word      = '0;
        n7_word.vld  = r6_vld;
        n7_word.dmag = r6_dmag;
        n7_word.sing = r6_dz || (r6_dmag < {49'b0, i_limit, 16'b0});
        for (int i = 0; i < NLANE; i++) begin
            n7_word.lane[i].rem = {32'b0, r6_cmag[i]};
            n7_word.lane[i].quo = '0;
            n7_word.lane[i].neg = r6_neg[i];
            n7_word.lane[i].ovf = ({32'b0, r6_cmag[i]} >= r6_dmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r7_word.vld <= 1'b0;
        end else if (i_en) begin
            r1_vld      <= i_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= r4_vld;
            r6_vld      <= r5_vld;
            r7_word     <= n7_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p      <= n1_p;
            r1_abc[0] <= a;
            r1_abc[1] <= b;
            r1_abc[2] <= c;
            r2_cof    <= n2_cof;
            r2_abc    <= r1_abc;
            r3_pl     <= n3_pl;
            r3_ph     <= n3_ph;
            r3_cof    <= r2_cof;
            r4_term   <= n4_term;
            r4_cof    <= r3_cof;
            r5_det    <= r4_term[0] + r4_term[1] + r4_term[2];
            r5_cof    <= r4_cof;
            r6_dmag   <= r5_det[DETW-1] ? (DETW'(0) - r5_det) : r5_det;
            r6_dz     <= (r5_det == '0);
            r6_cmag   <= n6_cmag;
            r6_neg    <= n6_neg;
        end
    end

    assign o_word = r7_word;

endmodule

### hw/rtl/matrix3x3_inverse_unit.sv
// Pipeline: 7 cofactor/determinant stages, 32 divider stages and 1 output
//   register; throughput one word a cycle while the output is not stalled.
// The divider takes one quotient bit per stage for all nine entries at once.
// Reset (synchronous, active low) empties the pipeline and sets
//   singular_limit to 4295; no clearing pass is needed.
// ----------------------------------------------------------------------------
// matrix3x3_inverse_unit: pipelined 3x3 adjugate inverse, Q16.16
// Exact determinant and cofactors, 32-step restoring division per entry,
// truncation toward zero and saturation; singular matrices give all zeros.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  m3i_pkg::t_in_word   i_in_word,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output m3i_pkg::t_out_word  o_out_word,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import m3i_pkg::*;

    // ---- configuration ----
    logic [31:0] r_limit;
    logic        cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2] == ADDR_LIMIT);
    assign prdata  = cfg_hit ? r_limit : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_limit <= pwdata;
        end
    end

    // ---- flow control ----
    // The whole pipe moves together; it halts only when the output register
    // holds a word that the sink is stalling. Bubbles travel as invalid words.
    logic en;
    logic r_out_vld;

    assign en         = !r_out_vld || !i_out_stall;
    assign o_in_stall = !en;

    // ---- cofactor / determinant front end ----
    t_div_word w_div [NSTEP+1];

    m3i_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_word  (i_in_word),
        .i_limit (r_limit),
        .o_word  (w_div[0])
    );

    // ---- divider: one quotient bit per stage ----
    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        m3i_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_word  (w_div[s]),
            .o_word  (w_div[s+1])
        );
    end

    // ---- sign, saturation, singular masking ----
    t_div_word         tail;
    logic [QW-1:0]     ent [NLANE];
    t_out_word         n_out;
    t_out_word         r_out;

    assign tail = w_div[NSTEP];

    always_comb begin
        logic [QW-1:0] q;
        for (int i = 0; i < NLANE; i++) begin
            q = tail.lane[i].quo;
            if (tail.sing) begin
                ent[i] = '0;
            end else if (tail.lane[i].ovf) begin
                ent[i] = tail.lane[i].neg ? SAT_NEG : SAT_POS;
            end else if (tail.lane[i].neg) begin
                ent[i] = (q > SAT_NEG) ? SAT_NEG : (QW'(0) - q);
            end else begin
                ent[i] = q[QW-1] ? SAT_POS : q;
            end
        end
        n_out.r11      = ent[0];
        n_out.r12      = ent[1];
        n_out.r13      = ent[2];
        n_out.r21      = ent[3];
        n_out.r22      = ent[4];
        n_out.r23      = ent[5];
        n_out.r31      = ent[6];
        n_out.r32      = ent[7];
        n_out.r33      = ent[8];
        n_out.singular = tail.sing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= tail.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

`ifndef SYNTHESIS
    // a singular word carries only zero entries
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.singular) |->
        (o_out_word.r11 == 0 && o_out_word.r12 == 0 && o_out_word.r13 == 0 &&
         o_out_word.r21 == 0 && o_out_word.r22 == 0 && o_out_word.r23 == 0 &&
         o_out_word.r31 == 0 && o_out_word.r32 == 0 && o_out_word.r33 == 0))
        else $error("singular word with nonzero entry");

    // input stalls exactly when a held output word is being stalled
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall not tied to output backpressure");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");
`endif

endmodule
